>>> rtl/core/ttycook_pkg.sv
// Package for the canonical terminal input cooker.
// Holds the line store sizing, the fixed port widths, register indexes and byte codes.
// Depends on nothing.
package ttycook_pkg;

  // Depth of the circular line store, in bytes (1 to 511, for the 9-bit stored_count).
  localparam int LINE_DEPTH = 256;
  localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int CNT_W      = $clog2(LINE_DEPTH + 1);
  localparam int SUM_W      = CNT_W + 1;

  // Fixed field widths of the ports.
  localparam int CFG_IDX_W    = 4;
  localparam int CFG_DATA_W   = 16;
  localparam int STORED_W     = 9;
  localparam int ERASE_W      = 10;
  localparam int MODE_W       = 7;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MODE_FLAGS  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTR_CHAR   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QUIT_CHAR   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ERASE_CHAR  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KILL_CHAR   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WERASE_CHAR = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LNEXT_CHAR  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_END    = 4'd7;

  // Register reset values.
  localparam logic [MODE_W-1:0]     RST_MODE_FLAGS  = 7'd57;
  localparam logic [7:0]            RST_INTR_CHAR   = 8'd3;
  localparam logic [7:0]            RST_QUIT_CHAR   = 8'd28;
  localparam logic [7:0]            RST_ERASE_CHAR  = 8'd127;
  localparam logic [7:0]            RST_KILL_CHAR   = 8'd21;
  localparam logic [7:0]            RST_WERASE_CHAR = 8'd23;
  localparam logic [7:0]            RST_LNEXT_CHAR  = 8'd22;
  localparam logic [CFG_DATA_W-1:0] RST_LINE_END    = 16'd4;

  // Mode flag bit positions.
  localparam int MF_CR_TO_NL = 0;
  localparam int MF_NL_TO_CR = 1;
  localparam int MF_LOWER    = 2;
  localparam int MF_CANON    = 3;
  localparam int MF_SIGNALS  = 4;
  localparam int MF_ECHO     = 5;
  localparam int MF_ECHOCTL  = 6;

  // Operation codes.
  localparam logic [1:0] OP_RECEIVE = 2'd0;
  localparam logic [1:0] OP_TAKE    = 2'd1;
  localparam logic [1:0] OP_FLUSH   = 2'd2;

  // Signal codes.
  localparam logic [1:0] SIG_NONE = 2'd0;
  localparam logic [1:0] SIG_INTR = 2'd1;
  localparam logic [1:0] SIG_QUIT = 2'd2;

  // Byte codes.
  localparam logic [7:0] CH_DEL   = 8'd127;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;
  localparam logic [7:0] CTL_FLIP    = 8'h40;

endpackage

>>> rtl/core/tty_canonical_input_cooker.sv
// Canonical terminal input cooker: line editing, signals, mapping and echo.
// Keeps the line bytes in one synchronous memory; uses ttycook_pkg.
//
// Channel   | Handshake                   | Word
// ----------+-----------------------------+------------------------------------
// command   | start & !busy               | operation, raw_byte
// result    | done (one cycle, no stall)  | accepted ... stored_count
// config    | cfg_valid & cfg_ready       | cfg_index, cfg_data
//
// A received byte that is stored, a signal or literal-next byte, a refused byte,
// a flush, an unknown operation and a take from an empty store finish at once: the
// result word appears in the cycle after the command and busy never rises. A take
// from a non-empty store reads the memory at the head in S_FETCH, then gives the
// result in S_TAKE. Erase, kill and word-erase repeat S_FETCH (memory read at the
// tail) and S_CHECK (compare) for each byte examined, erase for one byte at most;
// a walk ends in S_FETCH when it finds the store empty. Reset loads the register
// reset values and clears the head, the count and the literal-next flag; the line
// store and the result word registers keep their contents. The receiver cannot
// stall, so done is a plain one-cycle strobe; cfg_ready is always high.
module tty_canonical_input_cooker
  import ttycook_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            operation,
  input  logic [7:0]            raw_byte,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  done,
  output logic                  accepted,
  output logic [1:0]            signal_raised,
  output logic [1:0]            echo_length,
  output logic [7:0]            echo_first,
  output logic [7:0]            echo_second,
  output logic [ERASE_W-1:0]    erase_count,
  output logic                  wake_reader,
  output logic [7:0]            read_byte,
  output logic                  read_valid,
  output logic [STORED_W-1:0]   stored_count
);

  // One-hot sequencer states.
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FETCH = 4'b0010,
    S_CHECK = 4'b0100,
    S_TAKE  = 4'b1000
  } state_t;

  // What the memory walk is doing.
  typedef enum logic [1:0] {
    K_ERASE  = 2'd0,
    K_WERASE = 2'd1,
    K_KILL   = 2'd2,
    K_READ   = 2'd3
  } kind_t;

  state_t state;
  kind_t  kind;

  // Configuration registers.
  logic [MODE_W-1:0]     mode_flags;
  logic [7:0]            intr_char;
  logic [7:0]            quit_char;
  logic [7:0]            erase_char;
  logic [7:0]            kill_char;
  logic [7:0]            werase_char;
  logic [7:0]            lnext_char;
  logic [CFG_DATA_W-1:0] line_end_chars;

  // Line store and its pointers.
  logic [7:0]        line_store [LINE_DEPTH];
  logic [7:0]        rdata;
  logic [ADDR_W-1:0] raddr;
  logic [ADDR_W-1:0] head;
  logic [CNT_W-1:0]  count;
  logic              literal_pending;
  logic              word_phase;   // Word-erase: 0 while skipping blanks, 1 inside the word.
  logic [ERASE_W-1:0] erased;

  function automatic logic is_ctrl(input logic [7:0] c);
    return (c < CH_SPACE) || (c == CH_DEL);
  endfunction

  function automatic logic ends_line(input logic [7:0] c, input logic [15:0] le);
    return (c == CH_NL) || (c == le[7:0]) || ((le[15:8] != 8'd0) && (c == le[15:8]));
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  // Circular addresses of the tail byte and of the next free slot. Both sums stay
  // below twice the depth, the tail sum if count > 0, so one compare-subtract wraps them.
  logic [SUM_W-1:0]  tail_sum;
  logic [SUM_W-1:0]  free_sum;
  logic [ADDR_W-1:0] tail_addr;
  logic [ADDR_W-1:0] free_addr;
  logic [ADDR_W-1:0] head_inc;

  always_comb begin
    tail_sum = SUM_W'(head) + SUM_W'(count) - SUM_W'(1);
    free_sum = SUM_W'(head) + SUM_W'(count);
    if (tail_sum >= SUM_W'(LINE_DEPTH)) begin
      tail_addr = ADDR_W'(tail_sum - SUM_W'(LINE_DEPTH));
    end else begin
      tail_addr = ADDR_W'(tail_sum);
    end
    if (free_sum >= SUM_W'(LINE_DEPTH)) begin
      free_addr = ADDR_W'(free_sum - SUM_W'(LINE_DEPTH));
    end else begin
      free_addr = ADDR_W'(free_sum);
    end
    if (SUM_W'(head) + SUM_W'(1) == SUM_W'(LINE_DEPTH)) begin
      head_inc = '0;
    end else begin
      head_inc = ADDR_W'(SUM_W'(head) + SUM_W'(1));
    end
  end

  // Cooking of a byte that is going to be stored: CR/NL mapping, lowercase, echo.
  logic [7:0] cooked;
  logic [1:0] cook_elen;
  logic [7:0] cook_e1;
  logic [7:0] cook_e2;
  logic       cook_wake;

  always_comb begin
    cooked = raw_byte;
    if (raw_byte == CH_CR) begin
      if (mode_flags[MF_CR_TO_NL]) begin
        cooked = CH_NL;
      end
    end else if (raw_byte == CH_NL) begin
      if (mode_flags[MF_NL_TO_CR]) begin
        cooked = CH_CR;
      end
    end
    if (mode_flags[MF_LOWER] && (cooked >= CH_UPPER_A) && (cooked <= CH_UPPER_Z)) begin
      cooked = cooked + CASE_OFFSET;
    end
    cook_elen = 2'd0;
    cook_e1   = 8'd0;
    cook_e2   = 8'd0;
    if (mode_flags[MF_ECHO]) begin
      if (cooked == CH_NL) begin
        cook_elen = 2'd2;
        cook_e1   = CH_NL;
        cook_e2   = CH_CR;
      end else if (mode_flags[MF_ECHOCTL] && is_ctrl(cooked)) begin
        cook_elen = 2'd2;
        cook_e1   = CH_CARET;
        cook_e2   = cooked ^ CTL_FLIP;
      end else begin
        cook_elen = 2'd1;
        cook_e1   = cooked;
      end
    end
    cook_wake = mode_flags[MF_CANON] ? ends_line(cooked, line_end_chars) : 1'b1;
  end

  // Classification of a received byte, in priority order.
  logic store_full;
  logic hit_lnext;
  logic hit_intr;
  logic hit_quit;
  logic hit_erase;
  logic hit_werase;
  logic hit_kill;

  always_comb begin
    store_full = (count == CNT_W'(LINE_DEPTH));
    hit_lnext  = !literal_pending && (raw_byte == lnext_char);
    hit_intr   = !literal_pending && mode_flags[MF_SIGNALS] && (raw_byte == intr_char);
    hit_quit   = !literal_pending && mode_flags[MF_SIGNALS] && (raw_byte == quit_char);
    hit_erase  = !literal_pending && mode_flags[MF_CANON] && (raw_byte == erase_char);
    hit_werase = !literal_pending && mode_flags[MF_CANON] && (raw_byte == werase_char);
    hit_kill   = !literal_pending && mode_flags[MF_CANON] && (raw_byte == kill_char);
  end

  // Decision on the tail byte that the walk has just read.
  logic              drop;
  logic              walk_more;
  logic              next_phase;
  logic [ERASE_W:0]  erased_sum;
  logic [ERASE_W-1:0] erased_next;
  logic [CNT_W-1:0]  count_after;

  always_comb begin
    drop       = 1'b0;
    walk_more  = 1'b0;
    next_phase = word_phase;
    case (kind)
      K_ERASE: begin
        drop = !ends_line(rdata, line_end_chars);
      end
      K_KILL: begin
        drop      = !ends_line(rdata, line_end_chars);
        walk_more = drop;
      end
      K_WERASE: begin
        if (!word_phase && is_blank(rdata)) begin
          drop      = 1'b1;
          walk_more = 1'b1;
        end else begin
          // First non-blank byte switches to the word on this same byte.
          next_phase = 1'b1;
          drop       = !ends_line(rdata, line_end_chars) && !is_blank(rdata);
          walk_more  = drop;
        end
      end
      default: begin
        drop = 1'b0;
      end
    endcase
    erased_sum = {1'b0, erased} + (is_ctrl(rdata) ? (ERASE_W+1)'(2) : (ERASE_W+1)'(1));
    if (!mode_flags[MF_ECHO]) begin
      erased_next = erased;
    end else if (erased_sum > (ERASE_W+1)'({ERASE_W{1'b1}})) begin
      erased_next = {ERASE_W{1'b1}};
    end else begin
      erased_next = ERASE_W'(erased_sum);
    end
    count_after = drop ? (count - CNT_W'(1)) : count;
  end

  // The memory reads the head for a reader take and the tail for editing.
  assign raddr = (kind == K_READ) ? head : tail_addr;

  logic accept_cmd;
  logic store_we;

  assign accept_cmd = start && (state == S_IDLE);
  assign store_we   = accept_cmd && (operation == OP_RECEIVE) && !store_full &&
                      !hit_lnext && !hit_intr && !hit_quit &&
                      !hit_erase && !hit_werase && !hit_kill;

  always_ff @(posedge clk) begin
    if (store_we) begin
      line_store[free_addr] <= cooked;
    end
    rdata <= line_store[raddr];
  end

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_flags     <= RST_MODE_FLAGS;
      intr_char      <= RST_INTR_CHAR;
      quit_char      <= RST_QUIT_CHAR;
      erase_char     <= RST_ERASE_CHAR;
      kill_char      <= RST_KILL_CHAR;
      werase_char    <= RST_WERASE_CHAR;
      lnext_char     <= RST_LNEXT_CHAR;
      line_end_chars <= RST_LINE_END;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODE_FLAGS:  mode_flags     <= cfg_data[MODE_W-1:0];
        REG_INTR_CHAR:   intr_char      <= cfg_data[7:0];
        REG_QUIT_CHAR:   quit_char      <= cfg_data[7:0];
        REG_ERASE_CHAR:  erase_char     <= cfg_data[7:0];
        REG_KILL_CHAR:   kill_char      <= cfg_data[7:0];
        REG_WERASE_CHAR: werase_char    <= cfg_data[7:0];
        REG_LNEXT_CHAR:  lnext_char     <= cfg_data[7:0];
        REG_LINE_END:    line_end_chars <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Control state: sequencer, pointers and the literal-next flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      kind            <= K_ERASE;
      head            <= '0;
      count           <= '0;
      literal_pending <= 1'b0;
      word_phase      <= 1'b0;
      erased          <= '0;
      done            <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept_cmd) begin
            erased     <= '0;
            word_phase <= 1'b0;
            case (operation)
              OP_RECEIVE: begin
                if (store_full) begin
                  done <= 1'b1;
                end else if (hit_lnext) begin
                  literal_pending <= 1'b1;
                  done            <= 1'b1;
                end else if (hit_intr || hit_quit) begin
                  done <= 1'b1;
                end else if (hit_erase) begin
                  kind  <= K_ERASE;
                  state <= S_FETCH;
                end else if (hit_werase) begin
                  kind  <= K_WERASE;
                  state <= S_FETCH;
                end else if (hit_kill) begin
                  kind  <= K_KILL;
                  state <= S_FETCH;
                end else begin
                  count           <= count + CNT_W'(1);
                  literal_pending <= 1'b0;
                  done            <= 1'b1;
                end
              end
              OP_TAKE: begin
                if (count != '0) begin
                  kind  <= K_READ;
                  state <= S_FETCH;
                end else begin
                  done <= 1'b1;
                end
              end
              OP_FLUSH: begin
                head  <= '0;
                count <= '0;
                done  <= 1'b1;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_FETCH: begin
          // The read address is presented this cycle; an empty store ends the walk.
          if ((count == '0) && (kind != K_READ)) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else if (kind == K_READ) begin
            state <= S_TAKE;
          end else begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          word_phase <= next_phase;
          count      <= count_after;
          if (drop) begin
            erased <= erased_next;
          end
          if (walk_more) begin
            state <= S_FETCH;
          end else begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_TAKE: begin
          head  <= head_inc;
          count <= count - CNT_W'(1);
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result word registers; they are read only while done is high.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept_cmd) begin
          accepted      <= 1'b0;
          signal_raised <= SIG_NONE;
          echo_length   <= 2'd0;
          echo_first    <= 8'd0;
          echo_second   <= 8'd0;
          erase_count   <= '0;
          wake_reader   <= 1'b0;
          read_byte     <= 8'd0;
          read_valid    <= 1'b0;
          stored_count  <= STORED_W'(count);
          case (operation)
            OP_RECEIVE: begin
              if (!store_full) begin
                accepted <= 1'b1;
                if (hit_lnext) begin
                  signal_raised <= SIG_NONE;
                end else if (hit_intr) begin
                  signal_raised <= SIG_INTR;
                end else if (hit_quit) begin
                  signal_raised <= SIG_QUIT;
                end else if (!hit_erase && !hit_werase && !hit_kill) begin
                  echo_length  <= cook_elen;
                  echo_first   <= cook_e1;
                  echo_second  <= cook_e2;
                  wake_reader  <= cook_wake;
                  stored_count <= STORED_W'(count + CNT_W'(1));
                end
              end
            end
            OP_FLUSH: begin
              wake_reader  <= 1'b1;
              stored_count <= '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_FETCH: begin
        erase_count  <= erased;
        stored_count <= STORED_W'(count);
      end
      S_CHECK: begin
        erase_count  <= drop ? erased_next : erased;
        stored_count <= STORED_W'(count_after);
      end
      S_TAKE: begin
        read_byte    <= rdata;
        read_valid   <= 1'b1;
        stored_count <= STORED_W'(count - CNT_W'(1));
      end
      default: begin
      end
    endcase
  end

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for the canonical terminal input cooker.
// Drives command and register words, predicts every result word and compares it on done.
// Depends on ttycook_pkg and the tty_canonical_input_cooker RTL only.
`timescale 1ns / 100ps

module tb_top;
  import ttycook_pkg::*;

  // The package names no code for the fourth operation value; the block must ignore it.
  localparam logic [1:0] OP_UNDEFINED = 2'd3;

  // One result word, in port order.
  typedef struct packed {
    logic       acc;
    logic [1:0] sig;
    logic [1:0] elen;
    logic [7:0] e1;
    logic [7:0] e2;
    logic [9:0] dels;
    logic       wake;
    logic [7:0] rbyte;
    logic       rvalid;
    logic [8:0] stored;
  } cook_word_t;

  // The full register file, one field per register index.
  typedef struct packed {
    logic [MODE_W-1:0]     mode;
    logic [7:0]            intr_c;
    logic [7:0]            quit_c;
    logic [7:0]            erase_c;
    logic [7:0]            kill_c;
    logic [7:0]            werase_c;
    logic [7:0]            lnext_c;
    logic [CFG_DATA_W-1:0] line_end;
  } tty_regs_t;

  // One row of the directed table; typed rows carry a result that is obvious by inspection.
  typedef struct {
    logic [1:0] op;
    logic [7:0] b;
    bit         typed;
    cook_word_t want;
  } step_row_t;

  localparam tty_regs_t RESET_REGS = '{RST_MODE_FLAGS, RST_INTR_CHAR, RST_QUIT_CHAR,
                                       RST_ERASE_CHAR, RST_KILL_CHAR, RST_WERASE_CHAR,
                                       RST_LNEXT_CHAR, RST_LINE_END};

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic [1:0]            operation = OP_RECEIVE;
  logic [7:0]            raw_byte = 8'h00;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  busy, cfg_ready, done;
  logic                  accepted, wake_reader, read_valid;
  logic [1:0]            signal_raised, echo_length;
  logic [7:0]            echo_first, echo_second, read_byte;
  logic [ERASE_W-1:0]    erase_count;
  logic [STORED_W-1:0]   stored_count;

  // Directed rows that carry a typed result hand it to the checker alongside the command.
  bit         row_typed = 1'b0;
  cook_word_t row_want = '0;

  tty_canonical_input_cooker dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .raw_byte(raw_byte),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .accepted(accepted), .signal_raised(signal_raised),
    .echo_length(echo_length), .echo_first(echo_first), .echo_second(echo_second),
    .erase_count(erase_count), .wake_reader(wake_reader), .read_byte(read_byte),
    .read_valid(read_valid), .stored_count(stored_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Line discipline predictor. It keeps its own copy of the line store, the
  // head and count, the literal-next flag and the registers, and advances them
  // once per accepted command word.
  // ---------------------------------------------------------------------------
  tty_regs_t  regs;
  logic [7:0] line_mem [LINE_DEPTH];
  int         line_head;
  int         line_count;
  bit         lit_pending;
  int         del_total;

  cook_word_t expected_words [$];
  int         fault_count = 0;

  function automatic bit is_ctrl(logic [7:0] c);
    return c < 8'd32 || c == CH_DEL;
  endfunction

  // NL always ends a line; the EOF byte does too, even when it is NUL, while the
  // extra end-of-line byte only counts when it is nonzero.
  function automatic bit ends_line(logic [7:0] c);
    logic [7:0] extra;
    extra = regs.line_end[15:8];
    return c == CH_NL || c == regs.line_end[7:0] || (extra != 8'd0 && c == extra);
  endfunction

  function automatic logic [7:0] tail_byte();
    return line_mem[(line_head + line_count - 1) % LINE_DEPTH];
  endfunction

  // Removing a byte echoes two DELs for a control byte (it was shown as ^X)
  // and one for anything else, but only while echo is enabled.
  function automatic void drop_tail();
    logic [7:0] c;
    c = tail_byte();
    line_count--;
    if (regs.mode[MF_ECHO]) begin
      del_total += is_ctrl(c) ? 2 : 1;
      if (del_total > 1023) del_total = 1023;
    end
  endfunction

  function automatic cook_word_t cook_predict(logic [1:0] op, logic [7:0] b);
    cook_word_t w;
    logic [7:0] c;
    bit         lit;
    w = '0;
    c = b;
    del_total = 0;
    // A full store refuses every received byte, editing and signal bytes included.
    if (op == OP_RECEIVE && line_count < LINE_DEPTH) begin
      w.acc = 1'b1;
      lit = lit_pending;
      if (!lit && c == regs.lnext_c) begin
        lit_pending = 1'b1;
      end else if (!lit && regs.mode[MF_SIGNALS] && c == regs.intr_c) begin
        w.sig = SIG_INTR;
      end else if (!lit && regs.mode[MF_SIGNALS] && c == regs.quit_c) begin
        w.sig = SIG_QUIT;
      end else if (!lit && regs.mode[MF_CANON] && c == regs.erase_c) begin
        if (line_count > 0 && !ends_line(tail_byte())) drop_tail();
      end else if (!lit && regs.mode[MF_CANON] && c == regs.werase_c) begin
        // Skip trailing blanks first, then the word itself; never cross a line end.
        while (line_count > 0 && (tail_byte() == CH_SPACE || tail_byte() == CH_TAB))
          drop_tail();
        while (line_count > 0 && !ends_line(tail_byte()) &&
               tail_byte() != CH_SPACE && tail_byte() != CH_TAB)
          drop_tail();
      end else if (!lit && regs.mode[MF_CANON] && c == regs.kill_c) begin
        while (line_count > 0 && !ends_line(tail_byte())) drop_tail();
      end else begin
        if (c == CH_CR) begin
          if (regs.mode[MF_CR_TO_NL]) c = CH_NL;
        end else if (c == CH_NL) begin
          if (regs.mode[MF_NL_TO_CR]) c = CH_CR;
        end
        if (regs.mode[MF_LOWER] && c >= CH_UPPER_A && c <= CH_UPPER_Z) c = c + CASE_OFFSET;
        if (regs.mode[MF_ECHO]) begin
          if (c == CH_NL) begin
            w.elen = 2'd2; w.e1 = CH_NL; w.e2 = CH_CR;
          end else if (regs.mode[MF_ECHOCTL] && is_ctrl(c)) begin
            w.elen = 2'd2; w.e1 = CH_CARET; w.e2 = c ^ CTL_FLIP;
          end else begin
            w.elen = 2'd1; w.e1 = c;
          end
        end
        line_mem[(line_head + line_count) % LINE_DEPTH] = c;
        line_count++;
        w.wake = regs.mode[MF_CANON] ? ends_line(c) : 1'b1;
        lit_pending = 1'b0;
      end
    end else if (op == OP_TAKE) begin
      if (line_count > 0) begin
        w.rbyte = line_mem[line_head];
        w.rvalid = 1'b1;
        line_head = (line_head + 1) % LINE_DEPTH;
        line_count--;
      end
    end else if (op == OP_FLUSH) begin
      // Flush keeps a pending literal-next.
      line_head = 0;
      line_count = 0;
      w.wake = 1'b1;
    end
    w.dels = del_total[9:0];
    w.stored = line_count[8:0];
    return w;
  endfunction

  function automatic string word_text(cook_word_t w);
    return $sformatf("acc=%0d sig=%0d echo=%0d/%02h/%02h dels=%0d wake=%0d read=%0d/%02h stored=%0d",
                     w.acc, w.sig, w.elen, w.e1, w.e2, w.dels, w.wake, w.rvalid, w.rbyte,
                     w.stored);
  endfunction

  function automatic void flag_fault(string what);
    fault_count++;
    if (fault_count <= 10) $display("%0t ns: %s", $time, what);
  endfunction

  // ---------------------------------------------------------------------------
  // Checker. Everything here reads values from just before the clock edge, so
  // it sees exactly what the block sees. Within this one process the result
  // check comes first: a result can never belong to a word accepted on the same
  // edge, since done is registered and comes after the edge that takes the command.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_and_predict
    cook_word_t got, want;
    if (rst) begin
      regs = RESET_REGS;
      line_head = 0;
      line_count = 0;
      lit_pending = 1'b0;
    end else begin
      if (done) begin
        got = {accepted, signal_raised, echo_length, echo_first, echo_second, erase_count,
               wake_reader, read_byte, read_valid, stored_count};
        if (expected_words.size() == 0) begin
          flag_fault({"result word with nothing expected: ", word_text(got)});
        end else begin
          want = expected_words.pop_front();
          if (got !== want)
            flag_fault({"mismatch\n  expected ", word_text(want), "\n  actual   ",
                        word_text(got)});
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODE_FLAGS:  regs.mode     = cfg_data[MODE_W-1:0];
          REG_INTR_CHAR:   regs.intr_c   = cfg_data[7:0];
          REG_QUIT_CHAR:   regs.quit_c   = cfg_data[7:0];
          REG_ERASE_CHAR:  regs.erase_c  = cfg_data[7:0];
          REG_KILL_CHAR:   regs.kill_c   = cfg_data[7:0];
          REG_WERASE_CHAR: regs.werase_c = cfg_data[7:0];
          REG_LNEXT_CHAR:  regs.lnext_c  = cfg_data[7:0];
          REG_LINE_END:    regs.line_end = cfg_data;
          default: ;
        endcase
      end
      // The predictor always runs so that its state tracks the block; a typed
      // row only replaces the word that is queued.
      if (start && !busy) begin
        want = cook_predict(operation, raw_byte);
        expected_words.push_back(row_typed ? row_want : want);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver tasks. All of them are entered and left right after a rising edge.
  // ---------------------------------------------------------------------------

  // Presents one command word and holds it until the block takes it.
  task automatic issue(input logic [1:0] op, input logic [7:0] b, input bit typed,
                       input cook_word_t want);
    start <= 1'b1;
    operation <= op;
    raw_byte <= b;
    row_typed <= typed;
    row_want <= want;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Random sender gaps: each cycle stays idle with the given chance in percent.
  task automatic sender_gap(input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Lets every outstanding result come back so that registers can be changed.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0 || busy) @(posedge clk);
  endtask

  // Writes all eight registers back to back; valid stays high across the run of writes.
  task automatic load_config(input tty_regs_t r);
    logic [CFG_DATA_W-1:0] v;
    for (int i = 0; i <= int'(REG_LINE_END); i++) begin
      case (i)
        REG_MODE_FLAGS:  v = CFG_DATA_W'(r.mode);
        REG_INTR_CHAR:   v = CFG_DATA_W'(r.intr_c);
        REG_QUIT_CHAR:   v = CFG_DATA_W'(r.quit_c);
        REG_ERASE_CHAR:  v = CFG_DATA_W'(r.erase_c);
        REG_KILL_CHAR:   v = CFG_DATA_W'(r.kill_c);
        REG_WERASE_CHAR: v = CFG_DATA_W'(r.werase_c);
        REG_LNEXT_CHAR:  v = CFG_DATA_W'(r.lnext_c);
        default:         v = r.line_end;
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= i[CFG_IDX_W-1:0];
      cfg_data <= v;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // Received bytes lean toward text, blanks and whatever the current registers
  // make special, so that editing, signals and line ends happen often.
  function automatic logic [7:0] pick_byte(tty_regs_t r);
    int pick;
    pick = $urandom_range(99);
    if (pick < 35)
      return CH_UPPER_A + ($urandom_range(1) ? CASE_OFFSET : 8'd0) + 8'($urandom_range(25));
    if (pick < 45)
      return $urandom_range(1) ? CH_SPACE : CH_TAB;
    if (pick < 70) begin
      case ($urandom_range(9))
        0: return r.intr_c;
        1: return r.quit_c;
        2: return r.erase_c;
        3: return r.werase_c;
        4: return r.kill_c;
        5: return r.lnext_c;
        6: return r.line_end[7:0];
        7: return r.line_end[15:8];
        8: return CH_CR;
        default: return CH_NL;
      endcase
    end
    return 8'($urandom_range(255));
  endfunction

  // One random phase under one register setting. A low flush and take rate
  // lets the store fill up so that refused bytes are exercised.
  task automatic run_phase(input tty_regs_t r, input int items, input int idle_pct,
                           input int take_pct, input int flush_pct);
    int         pick;
    logic [1:0] op;
    drain();
    load_config(r);
    for (int n = 0; n < items; n++) begin
      sender_gap(idle_pct);
      pick = $urandom_range(99);
      if (pick < flush_pct)                 op = OP_FLUSH;
      else if (pick < flush_pct + take_pct) op = OP_TAKE;
      else if (pick < flush_pct + take_pct + 1) op = OP_UNDEFINED;
      else                                  op = OP_RECEIVE;
      issue(op, pick_byte(r), 1'b0, '0);
    end
  endtask

  // Builds one row of the directed table.
  function automatic step_row_t row(logic [1:0] op, logic [7:0] b, bit typed = 1'b0,
                                    cook_word_t want = '0);
    step_row_t s;
    s.op = op;
    s.b = b;
    s.typed = typed;
    s.want = want;
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    step_row_t  directed_rows [$];
    tty_regs_t  rand_regs;
    logic [7:0] c;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset register values: canonical, signals and
    // echo on, CR mapped to NL, no caret echo, EOF is ^D.
    directed_rows.push_back(row(OP_TAKE, 8'h00, 1'b1, '0));            // read of an empty store
    directed_rows.push_back(row(OP_RECEIVE, 8'h61, 1'b1,
                                cook_word_t'{1'b1, SIG_NONE, 2'd1, 8'h61, 8'h00, 10'd0,
                                             1'b0, 8'h00, 1'b0, 9'd1}));
    directed_rows.push_back(row(OP_RECEIVE, 8'hFF, 1'b1,
                                cook_word_t'{1'b1, SIG_NONE, 2'd1, 8'hFF, 8'h00, 10'd0,
                                             1'b0, 8'h00, 1'b0, 9'd2}));
    directed_rows.push_back(row(OP_RECEIVE, 8'h00, 1'b1,
                                cook_word_t'{1'b1, SIG_NONE, 2'd1, 8'h00, 8'h00, 10'd0,
                                             1'b0, 8'h00, 1'b0, 9'd3}));
    directed_rows.push_back(row(OP_RECEIVE, CH_UPPER_A));
    directed_rows.push_back(row(OP_RECEIVE, CH_TAB));
    directed_rows.push_back(row(OP_RECEIVE, 8'h77));
    directed_rows.push_back(row(OP_RECEIVE, RST_WERASE_CHAR));         // word stops at the tab
    directed_rows.push_back(row(OP_RECEIVE, RST_ERASE_CHAR));          // removes the tab
    directed_rows.push_back(row(OP_RECEIVE, RST_INTR_CHAR));
    directed_rows.push_back(row(OP_RECEIVE, RST_QUIT_CHAR));
    directed_rows.push_back(row(OP_RECEIVE, RST_LNEXT_CHAR));
    directed_rows.push_back(row(OP_RECEIVE, RST_INTR_CHAR));           // stored literally
    directed_rows.push_back(row(OP_RECEIVE, RST_LNEXT_CHAR));
    directed_rows.push_back(row(OP_RECEIVE, RST_LNEXT_CHAR));          // literal-next stored
    directed_rows.push_back(row(OP_RECEIVE, CH_CR));                   // becomes NL, ends line
    directed_rows.push_back(row(OP_RECEIVE, RST_ERASE_CHAR));          // blocked by the NL
    directed_rows.push_back(row(OP_RECEIVE, 8'h62));
    directed_rows.push_back(row(OP_RECEIVE, RST_KILL_CHAR));
    directed_rows.push_back(row(OP_RECEIVE, RST_LINE_END[7:0]));       // EOF wakes the reader
    directed_rows.push_back(row(OP_TAKE, 8'h00));
    directed_rows.push_back(row(OP_UNDEFINED, 8'h5A));
    directed_rows.push_back(row(OP_FLUSH, 8'h00, 1'b1,
                                cook_word_t'{1'b0, SIG_NONE, 2'd0, 8'h00, 8'h00, 10'd0,
                                             1'b1, 8'h00, 1'b0, 9'd0}));
    directed_rows.push_back(row(OP_UNDEFINED, 8'hA5, 1'b1, '0));
    directed_rows.push_back(row(OP_TAKE, 8'h00, 1'b1, '0));
    foreach (directed_rows[i]) begin
      sender_gap(8);
      issue(directed_rows[i].op, directed_rows[i].b, directed_rows[i].typed,
            directed_rows[i].want);
    end

    // Random phases. The sender idles 8 percent of cycles in the first two,
    // 77 percent in the next two and never in the rest.
    run_phase(RESET_REGS, 250, 8, 12, 2);
    // Every mode on; coinciding signal bytes (interrupt wins) and coinciding
    // editing bytes (erase wins); NUL acts as EOF and ';' ends a line as well.
    run_phase(tty_regs_t'{7'd127, 8'h03, 8'h03, 8'h08, 8'h08, 8'h08, 8'hFF, 16'h3B00},
              250, 8, 10, 0);
    // Every mode off: raw input, no echo; all-ones line end bytes.
    run_phase(tty_regs_t'{7'd0, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 16'hFFFF},
              250, 77, 15, 3);
    // NL mapped to CR with lowercase and caret echo; DEL interrupts, '@' kills,
    // backslash is literal-next, and the extra end-of-line byte is NL itself.
    run_phase(tty_regs_t'{7'd126, 8'h7F, 8'h1C, 8'h80, 8'h40, 8'h17, 8'h5C, 16'h0A04},
              250, 77, 8, 1);
    rand_regs.mode = MODE_W'($urandom_range(127));
    rand_regs.intr_c = 8'($urandom_range(31));
    rand_regs.quit_c = 8'($urandom_range(31));
    rand_regs.erase_c = 8'($urandom_range(31));
    rand_regs.kill_c = 8'($urandom_range(31));
    rand_regs.werase_c = 8'($urandom_range(31));
    rand_regs.lnext_c = 8'($urandom_range(31));
    rand_regs.line_end = {8'($urandom_range(31)), 8'($urandom_range(255))};
    run_phase(rand_regs, 250, 0, 12, 2);
    run_phase(RESET_REGS, 250, 0, 3, 0);

    // Deepest erase: fill the whole store with control bytes, show that one
    // more byte is refused, free one entry, then kill the remaining line.
    // Every special byte sits above 127 so no control byte is treated specially.
    drain();
    load_config(tty_regs_t'{7'd120, 8'h80, 8'h81, 8'h82, 8'h83, 8'h84, 8'h85, 16'h00FE});
    issue(OP_FLUSH, 8'h00, 1'b0, '0);
    for (int n = 0; n < LINE_DEPTH; n++) begin
      c = 8'($urandom_range(32));
      if (c == 8'd32) c = CH_DEL;
      if (c == CH_NL) c = CH_CR;
      issue(OP_RECEIVE, c, 1'b0, '0);
    end
    issue(OP_RECEIVE, 8'($urandom_range(255)), 1'b0, '0);
    issue(OP_TAKE, 8'h00, 1'b0, '0);
    issue(OP_RECEIVE, 8'h83, 1'b0, '0);

    // Wait out everything in flight, then a kill-length tail for stray results.
    drain();
    repeat (2 * LINE_DEPTH + 16) @(posedge clk);
    if (fault_count == 0 && expected_words.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run, including a full kill per word.
  initial begin : watchdog
    #(10_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
